FILE: hw/rtl/sfl_pkg.sv
// Shared types and constants for the substring first/last finder.
// Used by sfl_cell, sfl_tracker and substring_first_last_finder.
package sfl_pkg;

   // Default configuration of the block
   localparam int NEEDLE_MAX_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 16;

   // Fixed field widths
   localparam int BYTE_WIDTH   = 8;
   localparam int LEN_WIDTH    = 4;
   localparam int INDEX_WIDTH  = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LENGTH = 1'b1;

   // One result item
   typedef struct packed {
      logic [INDEX_WIDTH-1:0] first_index;
      logic [INDEX_WIDTH-1:0] last_index;
      logic [INDEX_WIDTH-1:0] hay_length;
      logic                   match_found;
      logic                   count_overflow;
   } sfl_result_type;

endpackage

FILE: hw/rtl/sfl_cell.sv
// One window cell: holds one haystack byte and compares the byte passing in
// against its needle byte. Depends on sfl_pkg.
module sfl_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic                           clear,
   input  logic                           active,
   input  logic [sfl_pkg::BYTE_WIDTH-1:0] byte_in,
   input  logic [sfl_pkg::BYTE_WIDTH-1:0] needle_byte,
   output logic [sfl_pkg::BYTE_WIDTH-1:0] byte_out,
   output logic                           hit
);
   import sfl_pkg::*;

   logic [BYTE_WIDTH-1:0] byte_ff;
   logic [BYTE_WIDTH-1:0] byte_in_next;

   // compare on the byte that lands here this cycle; idle cells always agree
   assign hit = !active || (byte_in == needle_byte);

   // clear at end of haystack, take the incoming byte on a shift, else hold
   always_comb begin
      byte_in_next = byte_ff;
      if (clear) begin
         byte_in_next = '0;
      end else if (shift_en) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

FILE: hw/rtl/sfl_tracker.sv
// Length counter and first/last match tracker; builds the result item.
// Depends on sfl_pkg.
module sfl_tracker #(
   parameter int COUNT_WIDTH = sfl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          hay_last,
   input  logic                          all_hit,
   input  logic [sfl_pkg::LEN_WIDTH-1:0] needle_len,
   output sfl_pkg::sfl_result_type       result
);
   import sfl_pkg::*;

   logic [COUNT_WIDTH-1:0] seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] earliest_ff, earliest_in;
   logic [COUNT_WIDTH-1:0] latest_ff, latest_in;
   logic                   any_ff, any_in;
   logic                   ovf_ff, ovf_in;

   logic                   at_limit;
   logic                   record;
   logic [COUNT_WIDTH-1:0] len_ext;
   logic [COUNT_WIDTH-1:0] start;
   logic [COUNT_WIDTH-1:0] first_sel, last_sel;
   logic [31:0]            first_wide, last_wide, seen_wide;

   assign len_ext  = COUNT_WIDTH'(needle_len);
   assign at_limit = (seen_ff == '1);

   // counter saturates; after overflow no start is recorded
   always_comb begin
      seen_in  = at_limit ? seen_ff : seen_ff + COUNT_WIDTH'(1);
      ovf_in   = ovf_ff || at_limit;
      record   = !at_limit && !ovf_ff && (needle_len != '0) &&
                 (seen_in >= len_ext) && all_hit;
      start    = seen_in - len_ext;
      earliest_in = (record && !any_ff) ? start : earliest_ff;
      latest_in   = record ? start : latest_ff;
      any_in      = any_ff || record;
   end

   // result selection for the final byte
   always_comb begin
      if (needle_len == '0) begin
         first_sel = '0;
         last_sel  = seen_in;
      end else if (any_in) begin
         first_sel = earliest_in;
         last_sel  = latest_in;
      end else begin
         first_sel = seen_in;
         last_sel  = seen_in;
      end
   end

   assign first_wide = 32'(first_sel);
   assign last_wide  = 32'(last_sel);
   assign seen_wide  = 32'(seen_in);

   always_comb begin
      result.first_index    = first_wide[INDEX_WIDTH-1:0];
      result.last_index     = last_wide[INDEX_WIDTH-1:0];
      result.hay_length     = seen_wide[INDEX_WIDTH-1:0];
      result.match_found    = (needle_len == '0) || any_in;
      result.count_overflow = ovf_in;
   end

   // stream state: advance per item, back to zero after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         earliest_ff <= '0;
         latest_ff   <= '0;
         any_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
      end else if (accept) begin
         if (hay_last) begin
            seen_ff     <= '0;
            earliest_ff <= '0;
            latest_ff   <= '0;
            any_ff      <= 1'b0;
            ovf_ff      <= 1'b0;
         end else begin
            seen_ff     <= seen_in;
            earliest_ff <= earliest_in;
            latest_ff   <= latest_in;
            any_ff      <= any_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

endmodule

FILE: hw/rtl/substring_first_last_finder.sv
// Substring first/last finder: top level with needle registers, cell chain
// and output register. Depends on sfl_pkg, sfl_cell and sfl_tracker.
//
// Takes one haystack byte per cycle, back to back, and returns one result
// item the cycle after the byte flagged last. The newest NEEDLE_MAX bytes sit
// in a chain of cells that shift one place per accepted byte; each cell
// compares its byte with one needle byte, and the tracker records the first
// and latest match start and the saturating length. The result sits in an
// output register; while it waits with the result channel stalled, every
// input item is stalled as well, so the input runs at one byte per cycle
// whenever results are taken as they appear. The user must write the needle
// registers only while no haystack is in flight; the block does not check.
module substring_first_last_finder #(
   parameter int NEEDLE_MAX  = sfl_pkg::NEEDLE_MAX_DEF,
   parameter int COUNT_WIDTH = sfl_pkg::COUNT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // haystack input
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sfl_pkg::BYTE_WIDTH-1:0]   req_hay_byte,
   input  logic                             req_hay_last,
   // result output
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sfl_pkg::INDEX_WIDTH-1:0]  rsp_first_index,
   output logic [sfl_pkg::INDEX_WIDTH-1:0]  rsp_last_index,
   output logic [sfl_pkg::INDEX_WIDTH-1:0]  rsp_hay_length,
   output logic                             rsp_match_found,
   output logic                             rsp_count_overflow,
   // configuration
   input  logic                             csr_write,
   input  logic [sfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sfl_pkg::*;

   logic [BYTE_WIDTH-1:0] needle_ff [NEEDLE_MAX];
   logic [LEN_WIDTH-1:0]  needle_len_ff;
   logic [LEN_WIDTH-1:0]  len_eff;

   logic                  accept;
   logic                  clear;
   logic [BYTE_WIDTH-1:0] win_q [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0] hit;
   logic                  all_hit;

   sfl_result_type        result;
   sfl_result_type        rsp_ff;
   logic                  rsp_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NEEDLE_MAX; m++) begin
            needle_ff[m] <= '0;
         end
         needle_len_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NEEDLE_BYTES: begin
               for (int m = 0; m < NEEDLE_MAX; m++) begin
                  needle_ff[m] <= csr_data[BYTE_WIDTH*m +: BYTE_WIDTH];
               end
            end
            CSR_NEEDLE_LENGTH: begin
               needle_len_ff <= csr_data[LEN_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // needle length clamped to the window size
   assign len_eff = (needle_len_ff > LEN_WIDTH'(NEEDLE_MAX)) ?
                    LEN_WIDTH'(NEEDLE_MAX) : needle_len_ff;

   // handshake: stall only while a result waits and is itself stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign clear     = accept && req_hay_last;

   // cell chain: cell k holds the byte k places back from the newest
   for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
      logic [BYTE_WIDTH-1:0] byte_in;
      logic [BYTE_WIDTH-1:0] needle_sel;
      logic                  active;

      if (k == 0) begin : g_head
         assign byte_in = req_hay_byte;
      end else begin : g_body
         assign byte_in = win_q[k-1];
      end

      // cell k pairs with needle byte len-1-k
      always_comb begin
         needle_sel = '0;
         for (int m = 0; m < NEEDLE_MAX; m++) begin
            if (LEN_WIDTH'(m) + LEN_WIDTH'(k) + LEN_WIDTH'(1) == len_eff) begin
               needle_sel = needle_ff[m];
            end
         end
      end

      assign active = LEN_WIDTH'(k) < len_eff;

      sfl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .clear       (clear),
         .active      (active),
         .byte_in     (byte_in),
         .needle_byte (needle_sel),
         .byte_out    (win_q[k]),
         .hit         (hit[k])
      );
   end

   assign all_hit = &hit;

   sfl_tracker #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .hay_last   (req_hay_last),
      .all_hit    (all_hit),
      .needle_len (len_eff),
      .result     (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_index    = rsp_ff.first_index;
   assign rsp_last_index     = rsp_ff.last_index;
   assign rsp_hay_length     = rsp_ff.hay_length;
   assign rsp_match_found    = rsp_ff.match_found;
   assign rsp_count_overflow = rsp_ff.count_overflow;

endmodule
